[rtl/ir_carrier_burst_segmenter_defines.svh]
// ----------------------------------------------------------------------------
// IR carrier burst segmenter assertion macros
// Shared concurrent assertion forms used by the segmenter RTL.
// ----------------------------------------------------------------------------
`ifndef IR_CARRIER_BURST_SEGMENTER_DEFINES_SVH
`define IR_CARRIER_BURST_SEGMENTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IRCBS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IRCBS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ircbs_pkg.sv]
// ----------------------------------------------------------------------------
// IR carrier burst segmenter package
// Types and fixed constants shared by the segmenter modules.
// ----------------------------------------------------------------------------
package ircbs_pkg;

  localparam int DUR_W  = 24;  // duration field width
  localparam int FREQ_W = 16;  // carrier frequency register width
  localparam int VAL_W  = 16;  // repetition value width
  localparam int KIND_W = 2;   // end marker width
  localparam int PROD_W = 40;  // duration * frequency plus rounding
  localparam int QUO_W  = 21;  // carrier period count width
  localparam int CNT_W  = 2;   // divider step counter width

  localparam int MAX_RESULTS = 17;

  localparam logic [FREQ_W-1:0] FREQ_RESET = 16'd38000;
  localparam logic [PROD_W-1:0] ROUND_HALF = 40'd500000;
  // Microseconds per second, the divisor.
  localparam logic [PROD_W-1:0] US_PER_S   = 40'd1000000;
  // Reciprocal of 3906.25 scaled by 2^43, applied to the dividend over 256.
  localparam logic [31:0]       RECIP_M     = 32'd2251799813;
  localparam int                RECIP_SHIFT = 43;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_WAIT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic [VAL_W-1:0] repeat_value;
    logic             carrier_on;
    logic             signal_end;
    logic             last_signal_end;
    logic             run_last;
  } entry_t;

endpackage

[rtl/ircbs_if.sv]
// ----------------------------------------------------------------------------
// IR carrier burst segmenter channels
// Valid/ready channels for the input symbols and the timer entries.
// ----------------------------------------------------------------------------
interface ircbs_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] duration_us;
  logic        level;
  logic [1:0]  end_kind;

  modport source (output valid, output duration_us, output level, output end_kind,
                  input ready);
  modport sink   (input valid, input duration_us, input level, input end_kind,
                  output ready);
endinterface

interface ircbs_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] repeat_value;
  logic        carrier_on;
  logic        signal_end;
  logic        last_signal_end;
  logic        run_last;

  modport source (output valid, output repeat_value, output carrier_on,
                  output signal_end, output last_signal_end, output run_last,
                  input ready);
  modport sink   (input valid, input repeat_value, input carrier_on,
                  input signal_end, input last_signal_end, input run_last,
                  output ready);
endinterface

[rtl/ircbs_div.sv]
// ----------------------------------------------------------------------------
// IR carrier burst segmenter divider
// Division by one million through a reciprocal estimate, a back multiply and
// one correction step, one step per cycle.
// ----------------------------------------------------------------------------
module ircbs_div import ircbs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [PROD_W-1:0] dividend,
  output logic [QUO_W-1:0]  quotient,
  output div_stat_t         stat
);

  logic [PROD_W-1:0] num_r, num_nxt;
  logic [PROD_W-1:0] rem_r, rem_nxt;
  logic [QUO_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [63:0]       est_prod;
  logic [PROD_W-1:0] est_back;

  // The estimate is never above the true quotient and at most one below it.
  assign est_prod = {32'd0, num_r[PROD_W-1:8]} * {32'd0, RECIP_M};
  assign est_back = {{(PROD_W-QUO_W){1'b0}}, quo_r} * US_PER_S;

  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt  = dividend;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(0)) begin
        quo_nxt = est_prod[RECIP_SHIFT +: QUO_W];
      end else if (cnt_r == CNT_W'(1)) begin
        rem_nxt = num_r - est_back;
      end else begin
        if (rem_r >= US_PER_S) begin
          quo_nxt = quo_r + QUO_W'(1);
        end
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

[rtl/ircbs_chunk.sv]
// ----------------------------------------------------------------------------
// IR carrier burst segmenter chunker
// Forms the next timer entry from the remaining period count.
// ----------------------------------------------------------------------------
module ircbs_chunk import ircbs_pkg::*; #(
  parameter int CHUNK_MAX = 65535
) (
  input  logic [QUO_W-1:0] rest,
  input  logic             filler,
  input  logic             level,
  input  logic             pend,
  input  logic             fend,
  output entry_t           entry,
  output logic [QUO_W-1:0] rest_nxt
);

  localparam logic [QUO_W-1:0] CHUNK = QUO_W'(CHUNK_MAX);

  logic [QUO_W-1:0] take;
  logic             last;

  always_comb begin
    if (filler) begin
      take = '0;
    end else begin
      take = (rest > CHUNK) ? CHUNK : rest;
    end
    rest_nxt = rest - take;
    last     = filler || (rest_nxt == '0);

    entry.repeat_value    = take[VAL_W-1:0];
    entry.carrier_on      = level && !filler;
    entry.signal_end      = last && pend;
    entry.last_signal_end = last && fend;
    entry.run_last        = last;
  end

endmodule

[rtl/ir_carrier_burst_segmenter.sv]
// ----------------------------------------------------------------------------
// IR carrier burst segmenter
// One item at a time: the item is captured, the product is formed and the
// three-step reciprocal division by one million runs, and the quotient is
// handed over; then one entry leaves per cycle that it is taken. An item
// with no entry frees the input once the quotient is in.
// Reset: synchronous active-low rst_n; carrier frequency returns to 38000 Hz.
// ----------------------------------------------------------------------------
`include "ir_carrier_burst_segmenter_defines.svh"

module ir_carrier_burst_segmenter import ircbs_pkg::*; #(
  parameter int CHUNK_MAX     = 65535,
  parameter int DURATION_BITS = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [FREQ_W-1:0] cfg_wr_data,
  ircbs_in_if.sink          in_ch,
  ircbs_out_if.source       out_ch
);

  // Largest duration that passes unsaturated, and the cap on the total
  // repetition count so that no item produces more than MAX_RESULTS entries.
  localparam logic [32:0]      DUR_MAX = (33'd1 << DURATION_BITS) - 33'd1;
  localparam logic [QUO_W-1:0] CAP     = QUO_W'(MAX_RESULTS * CHUNK_MAX);

  state_t            state_r, state_nxt;
  logic [FREQ_W-1:0] freq_r;
  logic [DUR_W-1:0]  dur_r, dur_nxt;
  logic              level_r, level_nxt;
  logic              pend_r, pend_nxt;
  logic              fend_r, fend_nxt;
  logic              filler_r, filler_nxt;
  logic [QUO_W-1:0]  rest_r, rest_nxt;

  logic [DUR_W-1:0]  dur_sat;
  logic [PROD_W-1:0] prod;
  logic              div_start;
  logic [QUO_W-1:0]  quotient;
  div_stat_t         div_stat;
  logic [QUO_W-1:0]  n_m1;
  entry_t            entry;
  logic [QUO_W-1:0]  chunk_rest;
  logic              in_acc;
  logic              out_acc;

  // Carrier frequency register; to be written only while the block is idle, which the block itself does not enforce.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r <= FREQ_RESET;
    end else if (cfg_wr_en) begin
      freq_r <= cfg_wr_data;
    end
  end

  // Durations beyond the configured width clamp to its maximum.
  assign dur_sat = ({9'd0, in_ch.duration_us} > DUR_MAX) ? DUR_MAX[DUR_W-1:0]
                                                         : in_ch.duration_us;

  // Periods = (duration * frequency + half a million) / one million. The
  // product with its rounding term is loaded straight into the divider.
  assign prod = ({{(PROD_W-DUR_W){1'b0}}, dur_r} * {{(PROD_W-FREQ_W){1'b0}}, freq_r})
                + ROUND_HALF;

  ircbs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod),
    .quotient (quotient),
    .stat     (div_stat)
  );

  // Total repetitions minus one, clamped so the chunk loop stays bounded.
  assign n_m1 = ((quotient - QUO_W'(1)) > CAP) ? CAP : (quotient - QUO_W'(1));

  ircbs_chunk #(
    .CHUNK_MAX (CHUNK_MAX)
  ) u_chunk (
    .rest     (rest_r),
    .filler   (filler_r),
    .level    (level_r),
    .pend     (pend_r),
    .fend     (fend_r),
    .entry    (entry),
    .rest_nxt (chunk_rest)
  );

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  // Sequencer: capture the item, multiply and start the divider, wait for
  // the quotient, then hand out entries until the final one is taken, if any.
  always_comb begin
    state_nxt  = state_r;
    dur_nxt    = dur_r;
    level_nxt  = level_r;
    pend_nxt   = pend_r;
    fend_nxt   = fend_r;
    filler_nxt = filler_r;
    rest_nxt   = rest_r;
    div_start  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          dur_nxt   = dur_sat;
          level_nxt = in_ch.level;
          pend_nxt  = (in_ch.end_kind != '0);
          fend_nxt  = in_ch.end_kind[KIND_W-1];
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        div_start = 1'b1;
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_stat.done) begin
          if (quotient == '0) begin
            // No carrier periods: a lone filler entry carries the end marks,
            // and a plain symbol produces nothing at all.
            filler_nxt = 1'b1;
            rest_nxt   = '0;
            state_nxt  = pend_r ? ST_EMIT : ST_IDLE;
          end else begin
            filler_nxt = 1'b0;
            rest_nxt   = n_m1;
            state_nxt  = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          rest_nxt = chunk_rest;
          if (entry.run_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    dur_r    <= dur_nxt;
    level_r  <= level_nxt;
    pend_r   <= pend_nxt;
    fend_r   <= fend_nxt;
    filler_r <= filler_nxt;
    rest_r   <= rest_nxt;
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // The entry is formed from registered state only, so it holds while the
  // output is stalled.
  assign in_ch.ready            = (state_r == ST_IDLE);
  assign out_ch.valid           = (state_r == ST_EMIT);
  assign out_ch.repeat_value    = entry.repeat_value;
  assign out_ch.carrier_on      = entry.carrier_on;
  assign out_ch.signal_end      = entry.signal_end;
  assign out_ch.last_signal_end = entry.last_signal_end;
  assign out_ch.run_last        = entry.run_last;

  `IRCBS_ASSERT_IMP(a_ready_excl_valid, clk, rst_n, in_ch.ready, !out_ch.valid, "input ready while an entry is pending")
  `IRCBS_ASSERT_NXT(a_last_frees_input, clk, rst_n, out_acc && out_ch.run_last, in_ch.ready, "input not ready after the final entry")
  `IRCBS_ASSERT_IMP(a_ends_on_last, clk, rst_n, out_ch.valid && !out_ch.run_last, !out_ch.signal_end && !out_ch.last_signal_end, "end mark on an inner entry")
  `IRCBS_ASSERT_IMP(a_div_idle, clk, rst_n, (state_r == ST_IDLE) || (state_r == ST_EMIT), !div_stat.busy && !div_stat.done, "divider active outside its wait")

endmodule

[bench/ircbs_tb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR carrier burst segmenter bench package
// End marker codes shared by the stimulus and the entry checker.
// ----------------------------------------------------------------------------
package ircbs_tb_pkg;

  // END_LAST_ALT is the fourth code, which the block treats as END_LAST.
  typedef enum logic [1:0] {
    END_MORE     = 2'd0,
    END_SIGNAL   = 2'd1,
    END_LAST     = 2'd2,
    END_LAST_ALT = 2'd3
  } end_kind_t;

endpackage

[bench/ircbs_entry_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR carrier burst segmenter entry checker
// Watches the symbol, entry and frequency ports, predicts the timer entries
// of every accepted symbol and compares them in order with the block output.
// ----------------------------------------------------------------------------
module ircbs_entry_checker import ircbs_pkg::*, ircbs_tb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [FREQ_W-1:0] cfg_wr_data,
  ircbs_in_if               in_mon,
  ircbs_out_if              out_mon,
  output int                error_count,
  output int                entries_due
);

  localparam int              REPORT_LIMIT = 10;
  localparam longint unsigned US_PER_SEC   = 64'd1000000;
  localparam longint unsigned CHUNK_LIMIT  = 64'd65535;

  logic [FREQ_W-1:0] carrier_hz;
  entry_t            pending_entries[$];
  int                mismatches = 0;
  int                queued     = 0;

  assign error_count = mismatches;
  assign entries_due = queued;

  // Carrier periods, rounded half up, split into timer chunks of at most 65535.
  function automatic void predict_entries(input logic [DUR_W-1:0] dur, input logic lvl,
                                          input logic [KIND_W-1:0] kind);
    longint unsigned periods;
    longint unsigned remaining;
    longint unsigned chunk;
    logic            pend;
    logic            fend;
    int              count;
    entry_t          e;
    periods = (longint'(dur) * longint'(carrier_hz) + US_PER_SEC / 2) / US_PER_SEC;
    pend    = (kind != END_MORE);
    fend    = (kind == END_LAST) || (kind == END_LAST_ALT);
    if (periods == 0) begin
      if (kind != END_MORE) begin
        e = '{repeat_value: '0, carrier_on: 1'b0, signal_end: pend,
              last_signal_end: fend, run_last: 1'b1};
        pending_entries.push_back(e);
      end
      return;
    end
    remaining = periods - 1;
    if (remaining > MAX_RESULTS * CHUNK_LIMIT) remaining = MAX_RESULTS * CHUNK_LIMIT;
    count = 0;
    do begin
      chunk = (remaining > CHUNK_LIMIT) ? CHUNK_LIMIT : remaining;
      remaining -= chunk;
      count++;
      e.repeat_value    = chunk[VAL_W-1:0];
      e.carrier_on      = lvl;
      e.signal_end      = (remaining == 0) ? pend : 1'b0;
      e.last_signal_end = (remaining == 0) ? fend : 1'b0;
      e.run_last        = (remaining == 0);
      pending_entries.push_back(e);
    end while (remaining != 0 && count < MAX_RESULTS);
  endfunction

  function automatic void report_entry(input string what, input entry_t want, input entry_t got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("%0t: %s: expected value %0d on %b pend %b fend %b last %b, got value %0d on %b pend %b fend %b last %b",
               $time, what, want.repeat_value, want.carrier_on, want.signal_end,
               want.last_signal_end, want.run_last, got.repeat_value, got.carrier_on,
               got.signal_end, got.last_signal_end, got.run_last);
    end
  endfunction

  always @(posedge clk) begin
    entry_t want;
    entry_t got;
    if (!rst_n) begin
      carrier_hz = FREQ_RESET;
      pending_entries.delete();
    end else begin
      if (cfg_wr_en) carrier_hz = cfg_wr_data;
      if (in_mon.valid && in_mon.ready) begin
        predict_entries(in_mon.duration_us, in_mon.level, in_mon.end_kind);
      end
      if (out_mon.valid && out_mon.ready) begin
        got.repeat_value    = out_mon.repeat_value;
        got.carrier_on      = out_mon.carrier_on;
        got.signal_end      = out_mon.signal_end;
        got.last_signal_end = out_mon.last_signal_end;
        got.run_last        = out_mon.run_last;
        if (pending_entries.size() == 0) begin
          report_entry("entry with none expected", '0, got);
        end else begin
          want = pending_entries.pop_front();
          if (got.repeat_value !== want.repeat_value || got.carrier_on !== want.carrier_on ||
              got.signal_end !== want.signal_end ||
              got.last_signal_end !== want.last_signal_end ||
              got.run_last !== want.run_last) begin
            report_entry("entry mismatch", want, got);
          end
        end
      end
    end
    queued = pending_entries.size();
  end

endmodule

[bench/tb_ir_carrier_burst_segmenter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR carrier burst segmenter testbench
// Drives marks and spaces into the segmenter under several carrier
// frequencies, with random gaps and stalls on both channels, and leaves the
// prediction and comparison of timer entries to the entry checker.
// ----------------------------------------------------------------------------
module tb_ir_carrier_burst_segmenter;
  import ircbs_pkg::*;
  import ircbs_tb_pkg::*;

  // A symbol passes the multiply, the division and the handover before its
  // first entry, and one with no entry is busy as long. The settle time covers that.
  localparam int SETTLE_CYCLES  = 30;
  // Longest quiet spell of a correct run is the long receiver hold-off
  // plus a settle pause; the watchdog allows several times that.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 40;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [FREQ_W-1:0] cfg_wr_data = '0;
  int                error_count;
  int                entries_due;

  // Idle switches for each side, redrawn per phase so that some stretches
  // run at full rate.
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  // A nonzero value asks the receiver for one long hold-off.
  int rx_hold_cycles = 0;
  // Frequency the block currently uses, for aiming durations at chunk edges.
  logic [FREQ_W-1:0] carrier_hz = FREQ_RESET;

  logic [FREQ_W-1:0] phase_freq [PHASES] = '{16'd38000, 16'd36000, 16'd1,
                                             16'd65535, 16'd56000, 16'd40000};

  ircbs_in_if  in_ch ();
  ircbs_out_if out_ch ();

  ir_carrier_burst_segmenter dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  ircbs_entry_checker entry_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .error_count (error_count),
    .entries_due (entries_due)
  );

  always #5 clk = ~clk;

  // Offers one symbol. It is entered and left at a falling edge; valid is only
  // lowered when a gap is drawn, so back-to-back symbols keep valid high
  // without a second assignment in the same time step.
  task automatic send_item(input logic [DUR_W-1:0] dur, input logic lvl,
                           input end_kind_t kind);
    int gap;
    gap = tx_idle_on ? $urandom_range(13, 0) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.duration_us <= dur;
    in_ch.level       <= lvl;
    in_ch.end_kind    <= kind;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Stops offering symbols and waits until every predicted entry has left,
  // then lets a symbol without entries finish inside the block.
  task automatic drain_entries();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (entries_due != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // The frequency register is only written while the block is idle.
  task automatic write_carrier_freq(input logic [FREQ_W-1:0] freq);
    drain_entries();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= freq;
    carrier_hz  = freq;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Result side: a random stall before each entry, or the one long hold-off
  // when the stimulus asks for it, counted here in the receiver's own process.
  initial begin : entry_sink
    int stall;
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      stall = rx_idle_on ? $urandom_range(13, 0) : 0;
      if (rx_hold_cycles > 0) begin
        stall = rx_hold_cycles;
        rx_hold_cycles = 0;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  // Watchdog: ends the run if neither channel moves an item for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    int              pick;
    logic [DUR_W-1:0] dur;
    end_kind_t       kind;
    longint unsigned span;

    in_ch.valid       = 1'b0;
    in_ch.duration_us = '0;
    in_ch.level       = 1'b0;
    in_ch.end_kind    = END_MORE;

    // Reset held from the start, released at a falling edge.
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed symbols at the reset frequency of 38 kHz. Zero periods give
    // nothing unless the symbol ends a signal, in which case a low filler
    // entry carries the end marks; the fourth end code acts as last signal.
    send_item(24'd0, 1'b1, END_MORE);
    send_item(24'd0, 1'b1, END_SIGNAL);
    send_item(24'd0, 1'b0, END_LAST);
    send_item(24'd0, 1'b1, END_LAST_ALT);
    // 13 us rounds to zero periods, 14 us to one.
    send_item(24'd13, 1'b1, END_MORE);
    send_item(24'd14, 1'b1, END_SIGNAL);
    // Just at and just past one full timer chunk.
    send_item(24'd1724631, 1'b1, END_SIGNAL);
    send_item(24'd1724658, 1'b0, END_MORE);
    send_item(24'hFFFFFF, 1'b1, END_LAST);
    send_item(24'hFFFFFF, 1'b0, END_MORE);
    send_item(24'd562, 1'b1, END_MORE);
    send_item(24'd1687, 1'b0, END_SIGNAL);

    // Highest frequency: the longest duration splits into the most entries.
    write_carrier_freq(16'd65535);
    send_item(24'hFFFFFF, 1'b1, END_LAST);
    send_item(24'd0, 1'b0, END_SIGNAL);
    send_item(24'd8, 1'b1, END_MORE);

    // Lowest nonzero frequency: rounding on the half-second boundary.
    write_carrier_freq(16'd1);
    send_item(24'd499999, 1'b1, END_SIGNAL);
    send_item(24'd500000, 1'b0, END_LAST);
    send_item(24'hFFFFFF, 1'b1, END_MORE);

    // 10 us at 50 kHz is exactly half a period and rounds up.
    write_carrier_freq(16'd50000);
    send_item(24'd10, 1'b1, END_MORE);
    send_item(24'd9, 1'b1, END_SIGNAL);

    // A zero frequency makes every symbol zero periods long.
    write_carrier_freq(16'd0);
    send_item(24'hFFFFFF, 1'b1, END_MORE);
    send_item(24'hFFFFFF, 1'b1, END_SIGNAL);

    // Random phases. The first runs with no idling on either side, the
    // second holds the receiver off for a long stretch so that the block
    // fills and stalls its input, and the last uses a random frequency.
    for (int p = 0; p < PHASES; p++) begin
      write_carrier_freq((p == PHASES - 1) ? 16'($urandom_range(65535, 1)) : phase_freq[p]);
      tx_idle_on = (p == 0) ? 1'b0 : 1'($urandom_range(1, 0));
      rx_idle_on = (p == 0) ? 1'b0 : 1'($urandom_range(1, 0));
      if (p == 1) rx_hold_cycles = HOLD_CYCLES;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Durations: mostly IR-like lengths, some near zero periods, some
        // over the whole field, and some aimed at a multiple of a chunk.
        pick = $urandom_range(9, 0);
        if (pick < 2) begin
          dur = DUR_W'($urandom_range(40, 0));
        end else if (pick == 2) begin
          dur = DUR_W'($urandom());
        end else if (pick == 3) begin
          span = (longint'($urandom_range(16, 1)) * 64'd65536 * 64'd1000000) / carrier_hz;
          span = span + $urandom_range(4, 0) - 2;
          dur  = (span > 64'hFFFFFF) ? 24'hFFFFFF : span[DUR_W-1:0];
        end else begin
          dur = DUR_W'($urandom_range(20000, 100));
        end
        pick = $urandom_range(9, 0);
        if (pick < 5) begin
          kind = END_MORE;
        end else if (pick < 7) begin
          kind = END_SIGNAL;
        end else if (pick < 9) begin
          kind = END_LAST;
        end else begin
          kind = END_LAST_ALT;
        end
        send_item(dur, 1'($urandom_range(1, 0)), kind);
      end
    end

    drain_entries();
    if (error_count == 0 && entries_due == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
